>>> rtl/esc_throttle_frame_encoder_assert.svh
// Assertion macros shared by the encoder modules.
`ifndef ESC_THROTTLE_FRAME_ENCODER_ASSERT_SVH
`define ESC_THROTTLE_FRAME_ENCODER_ASSERT_SVH
`ifndef SYNTHESIS
`define ETFE_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("etfe assertion failed");
`define ETFE_ASSERT_NOW(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("etfe assertion failed");
`else
`define ETFE_ASSERT(lbl, prop)
`define ETFE_ASSERT_NOW(lbl, prop)
`endif
`endif

>>> rtl/etfe_pkg.sv
package etfe_pkg;

    localparam int NUM_MOTORS_DEF = 4;
    localparam int FRAME_BITS     = 16;
    localparam int PROD_W         = 28;
    localparam int PW_W           = 14;

    localparam logic [15:0]       FULL_SCALE = 16'd32768;
    localparam logic [PROD_W-1:0] ROUND_HALF = 28'd16384;
    localparam logic [10:0]       DSHOT_MIN  = 11'd48;
    localparam logic [PW_W-1:0]   DSHOT_SPAN = 14'd1999;

    localparam logic [1:0] CFG_PROTOCOL = 2'd0;
    localparam logic [1:0] CFG_MAP      = 2'd1;
    localparam logic [1:0] CFG_ENABLE   = 2'd2;

    localparam logic [2:0] MODE_PWM   = 3'd0;
    localparam logic [2:0] MODE_OS125 = 3'd1;
    localparam logic [2:0] MODE_OS42  = 3'd2;
    localparam logic [2:0] MODE_DS150 = 3'd3;
    localparam logic [2:0] MODE_DS300 = 3'd4;
    localparam logic [2:0] MODE_DS600 = 3'd5;

    typedef logic [3:0] t_pc;

    localparam t_pc PC_IDLE     = 4'd0;
    localparam t_pc PC_DISPATCH = 4'd1;
    localparam t_pc PC_STORE    = 4'd2;
    localparam t_pc PC_PERM     = 4'd3;
    localparam t_pc PC_ENABLE   = 4'd4;
    localparam t_pc PC_MULT     = 4'd5;
    localparam t_pc PC_FORMAT   = 4'd6;
    localparam t_pc PC_ANALOG   = 4'd7;
    localparam t_pc PC_LOOP_A   = 4'd8;
    localparam t_pc PC_BIT      = 4'd9;
    localparam t_pc PC_NEXT     = 4'd10;
    localparam t_pc PC_LOOP_D   = 4'd11;
    localparam t_pc PC_PERM_ERR = 4'd12;
    localparam t_pc PC_OFF      = 4'd13;

    typedef enum logic [1:0] {
        ST_OK,
        ST_REJECT,
        ST_PERM,
        ST_NONE
    } t_status;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LATCH,
        OP_STORE,
        OP_CLR_MOTOR,
        OP_MULT,
        OP_FORMAT,
        OP_NEXT_MOTOR,
        OP_NEXT_BIT
    } t_op;

    typedef enum logic [2:0] {
        R_NONE,
        R_STORE,
        R_ANALOG,
        R_BIT,
        R_PERM,
        R_OFF
    } t_emit;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_NO_ACCEPT,
        C_SEND,
        C_PERM_BAD,
        C_DISABLED,
        C_DSHOT,
        C_LAST_MOTOR,
        C_MORE_BITS
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_emit emit;
        t_cond cond;
        t_pc   target;
    } t_uword;

    typedef struct packed {
        logic  fire;
        logic  accept;
        t_op   op;
        t_emit emit;
    } t_ctrl;

    typedef struct packed {
        logic out_free;
        logic send;
        logic perm_bad;
        logic disabled;
        logic dshot;
        logic last_motor;
        logic more_bits;
    } t_flags;

    function automatic t_uword ucode(t_pc pc);
        t_uword w;
        unique case (pc)
            PC_IDLE:     w = '{OP_LATCH,      R_NONE,   C_NO_ACCEPT,  PC_IDLE};
            PC_DISPATCH: w = '{OP_NONE,       R_NONE,   C_SEND,       PC_PERM};
            PC_STORE:    w = '{OP_STORE,      R_STORE,  C_ALWAYS,     PC_IDLE};
            PC_PERM:     w = '{OP_CLR_MOTOR,  R_NONE,   C_PERM_BAD,   PC_PERM_ERR};
            PC_ENABLE:   w = '{OP_NONE,       R_NONE,   C_DISABLED,   PC_OFF};
            PC_MULT:     w = '{OP_MULT,       R_NONE,   C_ALWAYS,     PC_FORMAT};
            PC_FORMAT:   w = '{OP_FORMAT,     R_NONE,   C_DSHOT,      PC_BIT};
            PC_ANALOG:   w = '{OP_NEXT_MOTOR, R_ANALOG, C_LAST_MOTOR, PC_IDLE};
            PC_LOOP_A:   w = '{OP_NONE,       R_NONE,   C_ALWAYS,     PC_MULT};
            PC_BIT:      w = '{OP_NEXT_BIT,   R_BIT,    C_MORE_BITS,  PC_BIT};
            PC_NEXT:     w = '{OP_NEXT_MOTOR, R_NONE,   C_LAST_MOTOR, PC_IDLE};
            PC_LOOP_D:   w = '{OP_NONE,       R_NONE,   C_ALWAYS,     PC_MULT};
            PC_PERM_ERR: w = '{OP_NONE,       R_PERM,   C_ALWAYS,     PC_IDLE};
            PC_OFF:      w = '{OP_NONE,       R_OFF,    C_ALWAYS,     PC_IDLE};
            default:     w = '{OP_NONE,       R_NONE,   C_ALWAYS,     PC_IDLE};
        endcase
        return w;
    endfunction

    function automatic logic [PW_W-1:0] span_of(logic [2:0] mode);
        logic [PW_W-1:0] s;
        unique case (mode)
            MODE_PWM:   s = 14'd8000;
            MODE_OS125: s = 14'd1000;
            MODE_OS42:  s = 14'd336;
            default:    s = DSHOT_SPAN;
        endcase
        return s;
    endfunction

    function automatic logic [PW_W-1:0] min_of(logic [2:0] mode);
        logic [PW_W-1:0] m;
        unique case (mode)
            MODE_PWM:   m = 14'd8000;
            MODE_OS125: m = 14'd1000;
            MODE_OS42:  m = 14'd336;
            default:    m = '0;
        endcase
        return m;
    endfunction

    function automatic logic [PW_W-1:0] dshot_width(logic [2:0] mode, logic b);
        logic [PW_W-1:0] w;
        unique case (mode)
            MODE_DS150: w = b ? 14'd40 : 14'd20;
            MODE_DS300: w = b ? 14'd20 : 14'd10;
            default:    w = b ? 14'd10 : 14'd5;
        endcase
        return w;
    endfunction

endpackage

>>> rtl/etfe_useq.sv
`include "esc_throttle_frame_encoder_assert.svh"

module etfe_useq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  etfe_pkg::t_flags i_flags,
    output etfe_pkg::t_ctrl  o_ctrl
);

    etfe_pkg::t_pc    r_pc;
    etfe_pkg::t_pc    n_pc;
    etfe_pkg::t_uword w;
    logic             accept;
    logic             hold;
    logic             cond_true;

    assign w          = etfe_pkg::ucode(r_pc);
    assign o_in_stall = (r_pc != etfe_pkg::PC_IDLE);
    assign accept     = i_in_valid && (r_pc == etfe_pkg::PC_IDLE);
    assign hold       = (w.emit != etfe_pkg::R_NONE) && !i_flags.out_free;

    always_comb begin
        unique case (w.cond)
            etfe_pkg::C_ALWAYS:     cond_true = 1'b1;
            etfe_pkg::C_NO_ACCEPT:  cond_true = !accept;
            etfe_pkg::C_SEND:       cond_true = i_flags.send;
            etfe_pkg::C_PERM_BAD:   cond_true = i_flags.perm_bad;
            etfe_pkg::C_DISABLED:   cond_true = i_flags.disabled;
            etfe_pkg::C_DSHOT:      cond_true = i_flags.dshot;
            etfe_pkg::C_LAST_MOTOR: cond_true = i_flags.last_motor;
            etfe_pkg::C_MORE_BITS:  cond_true = i_flags.more_bits;
            default:                cond_true = 1'b1;
        endcase
    end

    always_comb begin
        if (hold) begin
            n_pc = r_pc;
        end else if (cond_true) begin
            n_pc = w.target;
        end else begin
            n_pc = r_pc + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= etfe_pkg::PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctrl = '{fire: !hold, accept: accept, op: w.op, emit: w.emit};

    `ETFE_ASSERT_NOW(a_reset_idle, !i_rst_n |=> r_pc == etfe_pkg::PC_IDLE)
    `ETFE_ASSERT(a_accept_dispatch, accept |=> r_pc == etfe_pkg::PC_DISPATCH)
    `ETFE_ASSERT(a_hold_pc, hold |=> $stable(r_pc))

endmodule

>>> rtl/etfe_datapath.sv
`include "esc_throttle_frame_encoder_assert.svh"

module etfe_datapath #(
    parameter int NUM_MOTORS = etfe_pkg::NUM_MOTORS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  etfe_pkg::t_ctrl  i_ctrl,
    output etfe_pkg::t_flags o_flags,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [7:0]       i_cfg_data,
    input  logic             i_kind,
    input  logic [2:0]       i_motor,
    input  logic [15:0]      i_throttle,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [1:0]       o_motor_index,
    output logic [1:0]       o_channel,
    output logic [3:0]       o_bit_index,
    output logic [13:0]      o_high_time,
    output logic [1:0]       o_status,
    output logic             o_last
);

    localparam int MW = $clog2(NUM_MOTORS);
    localparam int PW = etfe_pkg::PW_W;
    localparam logic [3:0] LAST_BIT = 4'(etfe_pkg::FRAME_BITS - 1);

    logic [2:0]  r_mode;
    logic [7:0]  r_map;
    logic        r_oe;
    logic        r_kind;
    logic [2:0]  r_in_motor;
    logic [15:0] r_in_thr;
    logic [15:0] r_thr [NUM_MOTORS];
    logic [MW-1:0] r_motor;
    logic [3:0]  r_bit;
    logic [etfe_pkg::PROD_W-1:0] r_prod;
    logic [PW-1:0] r_width;
    logic [15:0] r_frame;

    logic             r_out_valid;
    logic [1:0]       r_out_motor;
    logic [1:0]       r_out_ch;
    logic [3:0]       r_out_bit;
    logic [PW-1:0]    r_out_pw;
    etfe_pkg::t_status r_out_status;
    logic             r_out_last;

    logic [1:0]       n_out_motor;
    logic [1:0]       n_out_ch;
    logic [3:0]       n_out_bit;
    logic [PW-1:0]    n_out_pw;
    etfe_pkg::t_status n_out_status;
    logic             n_out_last;

    logic        store_bad;
    logic        perm_bad;
    logic        last_motor;
    logic        more_bits;
    logic [1:0]  cur_ch;
    logic [15:0] cur_thr;
    logic [etfe_pkg::PROD_W-1:0] prod_full;
    logic [etfe_pkg::PROD_W-1:0] rounded;
    logic [12:0] scaled;
    logic [10:0] dval;
    logic [11:0] dword;
    logic [3:0]  csum;
    logic [3:0]  pos;
    logic        load;
    logic        err_out;

    assign store_bad  = (r_in_motor >= 3'(NUM_MOTORS)) || (r_in_thr > etfe_pkg::FULL_SCALE);
    assign last_motor = (r_motor == MW'(NUM_MOTORS - 1));
    assign more_bits  = (r_bit != LAST_BIT);
    assign cur_ch     = r_map[{r_motor, 1'b0} +: 2];
    assign cur_thr    = r_thr[r_motor];
    assign prod_full  = {14'd0, etfe_pkg::span_of(r_mode)} * {12'd0, cur_thr};
    assign rounded    = r_prod + etfe_pkg::ROUND_HALF;
    assign scaled     = rounded[etfe_pkg::PROD_W-1:15];
    assign dval       = scaled[10:0] + etfe_pkg::DSHOT_MIN;
    assign dword      = {dval, 1'b0};
    assign csum       = dword[3:0] ^ dword[7:4] ^ dword[11:8];
    assign pos        = LAST_BIT - r_bit;
    assign load       = i_ctrl.fire && (i_ctrl.emit != etfe_pkg::R_NONE);
    assign err_out    = r_out_valid && (r_out_status != etfe_pkg::ST_OK);

    always_comb begin
        perm_bad = 1'b0;
        for (int i = 1; i < NUM_MOTORS; i++) begin
            for (int j = 0; j < i; j++) begin
                if (r_map[2*i +: 2] == r_map[2*j +: 2]) begin
                    perm_bad = 1'b1;
                end
            end
        end
    end

    assign o_flags = '{
        out_free:   !r_out_valid || !i_out_stall,
        send:       r_kind,
        perm_bad:   perm_bad,
        disabled:   !r_oe || (r_mode > etfe_pkg::MODE_DS600),
        dshot:      (r_mode >= etfe_pkg::MODE_DS150),
        last_motor: last_motor,
        more_bits:  more_bits
    };

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= etfe_pkg::MODE_PWM;
            r_map  <= 8'd228;
            r_oe   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                etfe_pkg::CFG_PROTOCOL: r_mode <= i_cfg_data[2:0];
                etfe_pkg::CFG_MAP:      r_map  <= i_cfg_data;
                etfe_pkg::CFG_ENABLE:   r_oe   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_MOTORS; i++) begin
                r_thr[i] <= '0;
            end
        end else if (i_ctrl.fire && i_ctrl.op == etfe_pkg::OP_STORE && !store_bad) begin
            r_thr[r_in_motor[MW-1:0]] <= r_in_thr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motor <= '0;
            r_bit   <= '0;
            r_kind  <= 1'b0;
        end else if (i_ctrl.fire) begin
            case (i_ctrl.op)
                etfe_pkg::OP_LATCH: begin
                    if (i_ctrl.accept) begin
                        r_kind <= i_kind;
                    end
                end
                etfe_pkg::OP_CLR_MOTOR: r_motor <= '0;
                etfe_pkg::OP_MULT:      r_bit   <= '0;
                etfe_pkg::OP_NEXT_MOTOR: r_motor <= last_motor ? '0 : r_motor + MW'(1);
                etfe_pkg::OP_NEXT_BIT:  r_bit   <= r_bit + 4'd1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.fire && i_ctrl.op == etfe_pkg::OP_LATCH && i_ctrl.accept) begin
            r_in_motor <= i_motor;
            r_in_thr   <= i_throttle;
        end
        if (i_ctrl.fire && i_ctrl.op == etfe_pkg::OP_MULT) begin
            r_prod <= prod_full;
        end
        if (i_ctrl.fire && i_ctrl.op == etfe_pkg::OP_FORMAT) begin
            r_width <= etfe_pkg::min_of(r_mode) + {1'b0, scaled};
            r_frame <= {dword, csum};
        end
    end

    always_comb begin
        n_out_motor  = '0;
        n_out_ch     = '0;
        n_out_bit    = '0;
        n_out_pw     = '0;
        n_out_status = etfe_pkg::ST_OK;
        n_out_last   = 1'b1;
        unique case (i_ctrl.emit)
            etfe_pkg::R_STORE: begin
                n_out_motor  = store_bad ? 2'd0 : r_in_motor[1:0];
                n_out_status = store_bad ? etfe_pkg::ST_REJECT : etfe_pkg::ST_OK;
            end
            etfe_pkg::R_ANALOG: begin
                n_out_motor = 2'(r_motor);
                n_out_ch    = cur_ch;
                n_out_pw    = r_width;
                n_out_last  = last_motor;
            end
            etfe_pkg::R_BIT: begin
                n_out_motor = 2'(r_motor);
                n_out_ch    = cur_ch;
                n_out_bit   = pos;
                n_out_pw    = etfe_pkg::dshot_width(r_mode, r_frame[pos]);
                n_out_last  = last_motor && !more_bits;
            end
            etfe_pkg::R_PERM: n_out_status = etfe_pkg::ST_PERM;
            etfe_pkg::R_OFF:  n_out_status = etfe_pkg::ST_NONE;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_motor  <= n_out_motor;
            r_out_ch     <= n_out_ch;
            r_out_bit    <= n_out_bit;
            r_out_pw     <= n_out_pw;
            r_out_status <= n_out_status;
            r_out_last   <= n_out_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_motor_index = r_out_motor;
    assign o_channel     = r_out_ch;
    assign o_bit_index   = r_out_bit;
    assign o_high_time   = r_out_pw;
    assign o_status      = r_out_status;
    assign o_last        = r_out_last;

    `ETFE_ASSERT(a_motor_range, int'(r_motor) < NUM_MOTORS)
    `ETFE_ASSERT(a_err_final, err_out |-> r_out_last && r_out_pw == '0)
    `ETFE_ASSERT(a_out_hold, r_out_valid && i_out_stall |=> r_out_valid && $stable(r_out_pw))

endmodule

>>> rtl/esc_throttle_frame_encoder.sv
// Channel   Handshake                 Payload
// in        i_in_valid / o_in_stall   i_kind, i_motor, i_throttle
// out       o_out_valid / i_out_stall o_motor_index, o_channel, o_bit_index,
//                                     o_high_time, o_status, o_last
// cfg       i_cfg_we                  i_cfg_idx, i_cfg_data
//
// One item at a time; the microcode steps one word per cycle unless held.
// Store, map error and nothing sent each give one status result.
// Tick, analog: one pulse per motor; DShot: one pulse per frame bit per motor.
// Reset clears throttles to zero, sets identity map, mode 0, outputs off.
// A stalled, full output register freezes the step counter on an emitting step.
module esc_throttle_frame_encoder #(
    parameter int NUM_MOTORS = etfe_pkg::NUM_MOTORS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_kind,
    input  logic [2:0]  i_motor,
    input  logic [15:0] i_throttle,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_motor_index,
    output logic [1:0]  o_channel,
    output logic [3:0]  o_bit_index,
    output logic [13:0] o_high_time,
    output logic [1:0]  o_status,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data
);

    etfe_pkg::t_ctrl  ctrl;
    etfe_pkg::t_flags flags;

    etfe_useq u_useq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_flags    (flags),
        .o_ctrl     (ctrl)
    );

    etfe_datapath #(
        .NUM_MOTORS (NUM_MOTORS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (ctrl),
        .o_flags       (flags),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_kind        (i_kind),
        .i_motor       (i_motor),
        .i_throttle    (i_throttle),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_motor_index (o_motor_index),
        .o_channel     (o_channel),
        .o_bit_index   (o_bit_index),
        .o_high_time   (o_high_time),
        .o_status      (o_status),
        .o_last        (o_last)
    );

endmodule

>>> bench/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          MOTORS        = etfe_pkg::NUM_MOTORS_DEF;
    localparam logic        KIND_STORE    = 1'b0;
    localparam logic        KIND_TICK     = 1'b1;
    localparam logic [2:0]  MODE_OFF_A    = 3'd6;
    localparam logic [2:0]  MODE_OFF_B    = 3'd7;
    localparam logic [7:0]  MAP_IDENTITY  = 8'd228;
    localparam logic [7:0]  MAP_REVERSED  = 8'h1B;
    localparam logic [15:0] THR_FULL      = 16'd32768;
    localparam int          IDLE_LIMIT    = 4000;
    localparam int          SETTLE_CYCLES = 8;

    typedef struct packed {
        logic [1:0]        motor_index;
        logic [1:0]        channel;
        logic [3:0]        bit_index;
        logic [13:0]       high_time;
        etfe_pkg::t_status status;
        logic              last;
    } t_pulse_res;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        i_kind      = 1'b0;
    logic [2:0]  i_motor     = '0;
    logic [15:0] i_throttle  = '0;
    logic        i_out_stall = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [1:0]  i_cfg_idx   = '0;
    logic [7:0]  i_cfg_data  = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [1:0]  o_motor_index;
    logic [1:0]  o_channel;
    logic [3:0]  o_bit_index;
    logic [13:0] o_high_time;
    logic [1:0]  o_status;
    logic        o_last;

    t_pulse_res  expected_pulses [$];
    logic [15:0] thr_store [MOTORS];
    logic [2:0]  cfg_mode = etfe_pkg::MODE_PWM;
    logic [7:0]  cfg_map  = MAP_IDENTITY;
    logic        cfg_en   = 1'b0;
    logic        steady   = 1'b0;
    int          mismatches  = 0;
    int          stall_left  = 0;
    int          idle_cycles = 0;

    esc_throttle_frame_encoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_kind        (i_kind),
        .i_motor       (i_motor),
        .i_throttle    (i_throttle),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_motor_index (o_motor_index),
        .o_channel     (o_channel),
        .o_bit_index   (o_bit_index),
        .o_high_time   (o_high_time),
        .o_status      (o_status),
        .o_last        (o_last),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    function automatic int draw_wait();
        return steady ? 0 : $urandom_range(0, 7);
    endfunction

    function automatic void push_pulse(logic [1:0] mi, logic [1:0] ch, logic [3:0] bi,
                                       logic [13:0] pw, etfe_pkg::t_status st, logic fin);
        t_pulse_res r;
        r = '{mi, ch, bi, pw, st, fin};
        expected_pulses.push_back(r);
    endfunction

    function automatic void predict_pulses(logic kind, logic [2:0] motor, logic [15:0] thr);
        logic [3:0]  seen;
        logic        perm_ok;
        logic [1:0]  ch;
        int unsigned t, base, v, c, cs, frame, zero_w, one_w;
        logic        final_motor;
        if (kind == KIND_STORE) begin
            if (motor >= MOTORS || thr > THR_FULL) begin
                push_pulse('0, '0, '0, '0, etfe_pkg::ST_REJECT, 1'b1);
            end else begin
                thr_store[motor[1:0]] = thr;
                push_pulse(motor[1:0], '0, '0, '0, etfe_pkg::ST_OK, 1'b1);
            end
            return;
        end
        seen    = '0;
        perm_ok = 1'b1;
        for (int m = 0; m < MOTORS; m++) begin
            ch = cfg_map[2*m +: 2];
            if (seen[ch]) perm_ok = 1'b0;
            seen[ch] = 1'b1;
        end
        if (!perm_ok) begin
            push_pulse('0, '0, '0, '0, etfe_pkg::ST_PERM, 1'b1);
            return;
        end
        if (!cfg_en || cfg_mode > etfe_pkg::MODE_DS600) begin
            push_pulse('0, '0, '0, '0, etfe_pkg::ST_NONE, 1'b1);
            return;
        end
        for (int m = 0; m < MOTORS; m++) begin
            t           = thr_store[m];
            ch          = cfg_map[2*m +: 2];
            final_motor = (m == MOTORS - 1);
            if (cfg_mode <= etfe_pkg::MODE_OS42) begin
                case (cfg_mode)
                    etfe_pkg::MODE_PWM:   base = 8000;
                    etfe_pkg::MODE_OS125: base = 1000;
                    default:              base = 336;
                endcase
                push_pulse(2'(m), ch, '0, 14'(base + ((base * t + 16384) >> 15)),
                           etfe_pkg::ST_OK, final_motor);
            end else begin
                case (cfg_mode)
                    etfe_pkg::MODE_DS150: begin
                        zero_w = 20;
                        one_w  = 40;
                    end
                    etfe_pkg::MODE_DS300: begin
                        zero_w = 10;
                        one_w  = 20;
                    end
                    default: begin
                        zero_w = 5;
                        one_w  = 10;
                    end
                endcase
                v     = ((int'(etfe_pkg::DSHOT_SPAN) * t + 16384) >> 15)
                        + int'(etfe_pkg::DSHOT_MIN);
                c     = (v << 1) & 32'hFFF;
                cs    = (c ^ (c >> 4) ^ (c >> 8)) & 32'hF;
                frame = ((c << 4) | cs) & 32'hFFFF;
                for (int b = etfe_pkg::FRAME_BITS - 1; b >= 0; b--) begin
                    push_pulse(2'(m), ch, 4'(b), 14'(frame[b] ? one_w : zero_w),
                               etfe_pkg::ST_OK, final_motor && b == 0);
                end
            end
        end
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic check_field(string name, int got, int want);
        if (got != want) report_mismatch(name, got, want);
    endtask

    always @(posedge i_clk) begin
        t_pulse_res want;
        if (o_out_valid && !i_out_stall) begin
            if (expected_pulses.size() == 0) begin
                report_mismatch("result with nothing pending, high_time", o_high_time, 0);
            end else begin
                want = expected_pulses.pop_front();
                check_field("motor_index", o_motor_index, want.motor_index);
                check_field("channel", o_channel, want.channel);
                check_field("bit_index", o_bit_index, want.bit_index);
                check_field("high_time", o_high_time, want.high_time);
                check_field("status", o_status, int'(want.status));
                check_field("last", o_last, want.last);
            end
            stall_left = draw_wait();
        end
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("esc_throttle_frame_encoder: mismatch");
                $finish;
            end
        end
    end

    task automatic send_item(logic kind, logic [2:0] motor, logic [15:0] thr);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_motor    <= motor;
        i_throttle <= thr;
        do @(posedge i_clk); while (o_in_stall);
        predict_pulses(kind, motor, thr);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_pulses.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_settings(logic [2:0] mode, logic [7:0] map, logic en);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= etfe_pkg::CFG_PROTOCOL;
        i_cfg_data <= {5'd0, mode};
        @(posedge i_clk);
        cfg_mode    = mode;
        i_cfg_idx  <= etfe_pkg::CFG_MAP;
        i_cfg_data <= map;
        @(posedge i_clk);
        cfg_map     = map;
        i_cfg_idx  <= etfe_pkg::CFG_ENABLE;
        i_cfg_data <= {7'd0, en};
        @(posedge i_clk);
        cfg_en      = en;
        i_cfg_we   <= 1'b0;
    endtask

    task automatic test_store_limits();
        send_item(KIND_STORE, 3'd0, 16'd0);
        send_item(KIND_STORE, 3'd1, THR_FULL);
        send_item(KIND_STORE, 3'd2, THR_FULL + 16'd1);
        send_item(KIND_STORE, 3'd3, 16'hFFFF);
        send_item(KIND_STORE, 3'd4, 16'd100);
        send_item(KIND_STORE, 3'd7, 16'd0);
        send_item(KIND_STORE, 3'd3, 16'd16384);
        send_item(KIND_STORE, 3'd2, 16'd1);
    endtask

    task automatic test_tick_disabled();
        send_item(KIND_TICK, 3'd7, 16'hFFFF);
        wait_idle();
    endtask

    task automatic test_every_protocol();
        for (int md = 0; md < 8; md++) begin
            apply_settings(3'(md), MAP_IDENTITY, 1'b1);
            send_item(KIND_TICK, 3'd0, 16'd0);
            wait_idle();
        end
        apply_settings(etfe_pkg::MODE_PWM, MAP_REVERSED, 1'b1);
        send_item(KIND_TICK, 3'd0, 16'd0);
        wait_idle();
    endtask

    task automatic test_map_checks();
        apply_settings(etfe_pkg::MODE_DS600, 8'h00, 1'b1);
        send_item(KIND_TICK, 3'd0, 16'd0);
        wait_idle();
        apply_settings(MODE_OFF_A, 8'hFF, 1'b0);
        send_item(KIND_TICK, 3'd0, 16'd0);
        wait_idle();
        apply_settings(MODE_OFF_B, MAP_REVERSED, 1'b0);
        send_item(KIND_TICK, 3'd0, 16'd0);
        wait_idle();
    endtask

    task automatic test_random_traffic();
        int          ch [4];
        int          j, tmp;
        logic [7:0]  map;
        logic [15:0] thr;
        for (int phase = 0; phase < 8; phase++) begin
            steady = ($urandom_range(0, 3) == 0);
            ch = '{0, 1, 2, 3};
            for (int i = 3; i > 0; i--) begin
                j     = $urandom_range(0, i);
                tmp   = ch[i];
                ch[i] = ch[j];
                ch[j] = tmp;
            end
            map = 8'(ch[0] | (ch[1] << 2) | (ch[2] << 4) | (ch[3] << 6));
            if ($urandom_range(0, 4) == 0) map = 8'($urandom_range(0, 255));
            apply_settings(3'($urandom_range(0, 7)), map, $urandom_range(0, 6) != 0);
            for (int n = 0; n < 10; n++) begin
                case ($urandom_range(0, 5))
                    0:       thr = 16'd0;
                    1:       thr = THR_FULL;
                    2:       thr = THR_FULL - 16'd1;
                    3:       thr = 16'($urandom_range(0, 65535));
                    default: thr = 16'($urandom_range(0, 32768));
                endcase
                case ($urandom_range(0, 9))
                    0, 1, 2: send_item(KIND_TICK, 3'($urandom_range(0, 7)), thr);
                    3:       send_item(KIND_STORE, 3'($urandom_range(0, 7)), thr);
                    default: send_item(KIND_STORE, 3'($urandom_range(0, MOTORS - 1)), thr);
                endcase
            end
            wait_idle();
        end
        steady = 1'b0;
    endtask

    initial begin
        for (int m = 0; m < MOTORS; m++) thr_store[m] = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_store_limits();
        test_tick_disabled();
        test_every_protocol();
        test_map_checks();
        test_random_traffic();
        wait_idle();
        if (mismatches == 0) begin
            $display("esc_throttle_frame_encoder: match");
        end else begin
            $display("esc_throttle_frame_encoder: mismatch");
        end
        $finish;
    end
endmodule
